@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the frustum cull block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/fct_pkg.sv @@
// Types and constants shared by the frustum cull modules.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  localparam int COORD_W    = 32;
  localparam int RAD_W      = COORD_W - 1;
  localparam int NUM_PLANES = 6;
  localparam int NUM_CORNERS = 8;
  localparam int NEAR_PLANE = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_W     = 12;
  localparam int OFS_W      = 28;
  localparam int A_LSB      = 52;
  localparam int B_LSB      = 40;
  localparam int C_LSB      = 28;

  // Product of a Q1.10 normal and a Q16.16 coordinate, and the full Q.26 distance.
  localparam int PROD_W = COORD_W + COEF_W;
  localparam int DIST_W = (COORD_W + 13 > 43) ? COORD_W + 13 : 43;

  localparam int CNT_W = $clog2(NUM_CORNERS);

  // Queue depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_SPHERE = 1'b0,
    OP_CORNER = 1'b1
  } fct_op_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    fct_op_t                 op;
    logic                    rad_zero;
    logic                    sphere_out;
    logic [NUM_PLANES-1:0]   front;
    logic [COORD_W-1:0]      near;
  } fct_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } fct_qstat_t;

endpackage

`default_nettype wire

@@ design/frustum_cull_test_core.sv @@
// Frustum cull core: a sphere item and eight corner items per volume give one result item.
// Throughput is one input item per cycle while in_stall is low; a volume of nine items yields one result.
// The eighth corner passes the two multiply/sum stages, the queue write and then the result
// register; a stalled output can hold it in the queue.
// rst is synchronous and active high; it clears the plane registers to zero,
// the volume state, the queue and all valid flags. Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module frustum_cull_test_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [0:0]                     op,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_x,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_y,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_z,
  input  wire logic [fct_pkg::RAD_W-1:0]      radius,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                visible,
  output logic [fct_pkg::COORD_W-1:0]         near_distance
);
  import fct_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       corner_pop;
  fct_item_t  push_item;
  fct_item_t  head_item;
  fct_qstat_t q_stat;

  assign cfg_ready  = 1'b1;
  assign corner_pop = q_pop && head_item.op == OP_CORNER;

  fct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .op        (op),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .radius    (radius),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  fct_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_item),
    .pop   (q_pop),
    .rdata (head_item),
    .stat  (q_stat)
  );

  fct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_item        (head_item),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .visible       (visible),
    .near_distance (near_distance)
  );

  // The front end reserves queue space, so a push never meets a full queue.
  `ASSERT_CLK(a_no_overflow, !(q_push && q_stat.full && !q_pop), "queue overflow")
  // A result appears only after a corner item was taken from the queue.
  `ASSERT_CLK(a_result_from_corner, $rose(out_valid) |-> $past(corner_pop), "result without corner")
  // Nothing leaves an empty queue.
  `ASSERT_CLK(a_no_underflow, !(q_pop && q_stat.empty), "pop from empty queue")

endmodule

`default_nettype wire

@@ design/fct_front.sv @@
// Front end: plane registers, dot-product pipeline and per-item classification.
`timescale 1ns / 1ps
`default_nettype none

module fct_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic [0:0]                     op,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_x,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_y,
  input  wire logic [fct_pkg::COORD_W-1:0]    pos_z,
  input  wire logic [fct_pkg::RAD_W-1:0]      radius,
  input  wire fct_pkg::fct_qstat_t            q_stat,
  output logic                                in_stall,
  output logic                                q_push,
  output fct_pkg::fct_item_t                  q_item
);
  import fct_pkg::*;

  localparam int Q_W = DIST_W - 10;

  logic [CFG_DATA_W-1:0] plane [NUM_PLANES];

  // Stage 1: products.
  logic                      v1;
  fct_op_t                   op1;
  logic [RAD_W-1:0]          rad1;
  logic signed [PROD_W-1:0]  px [NUM_PLANES];
  logic signed [PROD_W-1:0]  py [NUM_PLANES];
  logic signed [PROD_W-1:0]  pz [NUM_PLANES];

  // Stage 2: distances.
  logic                      v2;
  fct_op_t                   op2;
  logic [RAD_W-1:0]          rad2;
  logic signed [DIST_W-1:0]  pdist [NUM_PLANES];
  logic signed [DIST_W-1:0]  pdist_next [NUM_PLANES];

  logic                      accept;
  logic [QCNT_W:0]           occupancy;
  logic signed [DIST_W-1:0]  nrad;
  logic [NUM_PLANES-1:0]     out_hit;
  logic [Q_W-1:0]            near_q;
  logic [COORD_W-1:0]        near_sat;

  // Items in the pipeline already hold a queue slot, so nothing is dropped.
  assign occupancy = {1'b0, q_stat.count} + (QCNT_W+1)'(v1) + (QCNT_W+1)'(v2);
  assign in_stall  = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) plane[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_PLANES)) begin
      plane[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= fct_op_t'(op);
    rad1 <= radius;
    for (int i = 0; i < NUM_PLANES; i++) begin
      px[i] <= $signed(plane[i][A_LSB +: COEF_W]) * $signed(pos_x);
      py[i] <= $signed(plane[i][B_LSB +: COEF_W]) * $signed(pos_y);
      pz[i] <= $signed(plane[i][C_LSB +: COEF_W]) * $signed(pos_z);
    end
    op2  <= op1;
    rad2 <= rad1;
    for (int i = 0; i < NUM_PLANES; i++) pdist[i] <= pdist_next[i];
  end

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      pdist_next[i] = $signed({{(DIST_W-PROD_W){px[i][PROD_W-1]}}, px[i]})
                    + $signed({{(DIST_W-PROD_W){py[i][PROD_W-1]}}, py[i]})
                    + $signed({{(DIST_W-PROD_W){pz[i][PROD_W-1]}}, pz[i]})
                    + $signed({{(DIST_W-OFS_W-14){plane[i][OFS_W-1]}},
                               plane[i][OFS_W-1:0], 14'b0});
    end
  end

  // Radius brought to Q.26 and negated for the outside test.
  assign nrad = -$signed({{(DIST_W-RAD_W-10){1'b0}}, rad2, 10'b0});

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) out_hit[i] = pdist[i] <= nrad;
  end

  // Floor division by 1024 is an arithmetic shift; then clamp to the coordinate range.
  assign near_q = pdist[NEAR_PLANE][DIST_W-1:10];

  always_comb begin
    if (&near_q[Q_W-1:COORD_W-1] || ~|near_q[Q_W-1:COORD_W-1]) begin
      near_sat = near_q[COORD_W-1:0];
    end else if (near_q[Q_W-1]) begin
      near_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      near_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_comb begin
    q_push            = v2;
    q_item.op         = op2;
    q_item.rad_zero   = ~|rad2;
    q_item.sphere_out = |out_hit;
    q_item.near       = near_sat;
    for (int i = 0; i < NUM_PLANES; i++) q_item.front[i] = pdist[i] > 0;
  end

endmodule

`default_nettype wire

@@ design/fct_queue.sv @@
// Short item queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module fct_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire fct_pkg::fct_item_t wdata,
  input  wire logic               pop,
  output fct_pkg::fct_item_t      rdata,
  output fct_pkg::fct_qstat_t     stat
);
  import fct_pkg::*;

  fct_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign do_push = push && (count != QCNT_W'(QUEUE_DEPTH) || pop);
  assign do_pop  = pop && count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  assign rdata      = mem[rptr];
  assign stat.count = count;
  assign stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count == '0;

endmodule

`default_nettype wire

@@ design/fct_back.sv @@
// Back end: per-volume state and the registered result.
`timescale 1ns / 1ps
`default_nettype none

module fct_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fct_pkg::fct_item_t          q_item,
  input  wire fct_pkg::fct_qstat_t         q_stat,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             visible,
  output logic [fct_pkg::COORD_W-1:0]      near_distance
);
  import fct_pkg::*;

  logic                   sphere_outside;
  logic                   volume_unset;
  logic [NUM_PLANES-1:0]  plane_seen_front;
  logic [CNT_W-1:0]       corner_count;
  logic [COORD_W-1:0]     centre_near_dist;
  logic [NUM_PLANES-1:0]  seen_next;
  logic                   last_corner;

  // A new item is taken only when the result register is free or drains this cycle.
  assign q_pop       = !q_stat.empty && (!out_valid || !out_stall);
  assign seen_next   = plane_seen_front | q_item.front;
  assign last_corner = corner_count == CNT_W'(NUM_CORNERS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_outside   <= 1'b0;
      volume_unset     <= 1'b0;
      plane_seen_front <= '0;
      corner_count     <= '0;
      centre_near_dist <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (q_pop && q_item.op == OP_CORNER && last_corner) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.op == OP_SPHERE) begin
          sphere_outside   <= q_item.sphere_out;
          volume_unset     <= q_item.rad_zero;
          centre_near_dist <= q_item.near;
          plane_seen_front <= '0;
          corner_count     <= '0;
        end else if (last_corner) begin
          plane_seen_front <= '0;
          corner_count     <= '0;
        end else begin
          plane_seen_front <= seen_next;
          corner_count     <= corner_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_CORNER && last_corner) begin
      visible       <= volume_unset || (!sphere_outside && &seen_next);
      near_distance <= centre_near_dist;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the frustum cull core: queued points, clocked driver and monitor.
`timescale 1ns / 1ps

module tb_top;
  import fct_pkg::*;

  localparam int     SETTLE_CYCLES = 8;
  localparam int     LONG_HOLD     = 300;
  localparam int     TIMEOUT_NS    = 3_000_000;
  localparam longint COORD_ONE     = 65536;  // 1.0 in Q16.16
  localparam int     NORMAL_ONE    = 1024;   // 1.0 in Q1.10
  localparam int     OFS_ONE       = 4096;   // 1.0 in Q16.12
  localparam int     COEF_MAX      = 2047;
  localparam int     COEF_MIN      = -2048;
  localparam int     OFS_MAX       = (1 << (OFS_W - 1)) - 1;
  localparam int     OFS_MIN       = -(1 << (OFS_W - 1));
  localparam longint NEAR_MAX      = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint NEAR_MIN      = -NEAR_MAX - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_RIGHT,
    PLANE_LEFT,
    PLANE_BOTTOM,
    PLANE_TOP,
    PLANE_FAR,
    PLANE_NEAR,
    PLANE_SPARE_A,
    PLANE_SPARE_B
  } plane_idx_t;

  typedef struct packed {
    fct_op_t            op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [RAD_W-1:0]   rad;
  } cull_point_t;

  typedef struct packed {
    logic               visible;
    logic [COORD_W-1:0] near_distance;
  } cull_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [0:0]            op = '0;
  logic [COORD_W-1:0]    pos_x = '0;
  logic [COORD_W-1:0]    pos_y = '0;
  logic [COORD_W-1:0]    pos_z = '0;
  logic [RAD_W-1:0]      radius = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  visible;
  logic [COORD_W-1:0]    near_distance;

  frustum_cull_test_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .radius        (radius),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .visible       (visible),
    .near_distance (near_distance)
  );

  cull_point_t   pending_points[$];
  cull_verdict_t expected_verdicts[$];
  cull_point_t   cur_point;
  cull_verdict_t verdict_due;
  int            points_queued = 0;
  int            err_count = 0;
  int            box_half = 100;
  int            tx_gap_pct = 0;
  int            rx_stall_pct = 0;
  logic          tx_paused = 1'b0;
  int            rx_hold_token = 0;
  int            rx_hold_seen = 0;
  int            rx_hold_cnt = 0;

  // Mirror of the plane registers and the volume being culled.
  logic [CFG_DATA_W-1:0] plane_cfg [NUM_PLANES] = '{default: '0};
  logic                  sphere_culled = 1'b0;
  logic                  volume_unset = 1'b0;
  logic [NUM_PLANES-1:0] front_mask = '0;
  logic [CNT_W-1:0]      corners_seen = '0;
  logic [COORD_W-1:0]    centre_near = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

  // Exact signed distance at Q.26.
  function automatic logic signed [63:0] plane_distance(logic [CFG_DATA_W-1:0] pl,
                                                        logic [COORD_W-1:0] x,
                                                        logic [COORD_W-1:0] y,
                                                        logic [COORD_W-1:0] z);
    logic signed [63:0] ca, cb, cc, ofs;
    ca  = $signed(pl[A_LSB +: COEF_W]);
    cb  = $signed(pl[B_LSB +: COEF_W]);
    cc  = $signed(pl[C_LSB +: COEF_W]);
    ofs = $signed(pl[OFS_W-1:0]);
    return ca * $signed(x) + cb * $signed(y) + cc * $signed(z) + (ofs <<< 14);
  endfunction

  function automatic logic [COORD_W-1:0] near_of(logic signed [63:0] full_dist);
    logic signed [63:0] q;
    q = full_dist >>> 10;
    if (q > NEAR_MAX) return NEAR_MAX[COORD_W-1:0];
    if (q < NEAR_MIN) return NEAR_MIN[COORD_W-1:0];
    return q[COORD_W-1:0];
  endfunction

  function automatic void predict_cull(cull_point_t pt);
    logic signed [63:0] neg_rad;
    cull_verdict_t      v;
    int                 p;
    if (pt.op == OP_SPHERE) begin
      neg_rad = -(64'(pt.rad) << 10);
      sphere_culled = 1'b0;
      for (p = 0; p < NUM_PLANES; p++) begin
        if (plane_distance(plane_cfg[p], pt.x, pt.y, pt.z) <= neg_rad) sphere_culled = 1'b1;
      end
      volume_unset = (pt.rad == '0);
      centre_near = near_of(plane_distance(plane_cfg[NEAR_PLANE], pt.x, pt.y, pt.z));
      front_mask = '0;
      corners_seen = '0;
    end else begin
      for (p = 0; p < NUM_PLANES; p++) begin
        if (plane_distance(plane_cfg[p], pt.x, pt.y, pt.z) > 0) front_mask[p] = 1'b1;
      end
      if (corners_seen == CNT_W'(NUM_CORNERS - 1)) begin
        v.visible = volume_unset || (!sphere_culled && (&front_mask));
        v.near_distance = centre_near;
        expected_verdicts.push_back(v);
        front_mask = '0;
        corners_seen = '0;
      end else begin
        corners_seen = corners_seen + 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_cull(cur_point);
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && !tx_paused && $urandom_range(99) >= tx_gap_pct) begin
          cur_point = pending_points.pop_front();
          op       <= cur_point.op;
          pos_x    <= cur_point.x;
          pos_y    <= cur_point.y;
          pos_z    <= cur_point.z;
          radius   <= cur_point.rad;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, started by a token change and timed here.
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_cnt <= 0;
    end else if (rx_hold_token != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_token;
      rx_hold_cnt  <= LONG_HOLD;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result item: visible=%0b near_distance=%0d",
                 visible, $signed(near_distance));
          err_count++;
        end else begin
          verdict_due = expected_verdicts.pop_front();
          if (visible !== verdict_due.visible) begin
            $error("visible: expected %0b, actual %0b", verdict_due.visible, visible);
            err_count++;
          end
          if (near_distance !== verdict_due.near_distance) begin
            $error("near_distance: expected %0d, actual %0d",
                   $signed(verdict_due.near_distance), $signed(near_distance));
            err_count++;
          end
        end
      end
      out_stall <= (rx_hold_cnt != 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic push_point(fct_op_t o, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic [RAD_W-1:0] r);
    cull_point_t pt;
    pt.op  = o;
    pt.x   = x;
    pt.y   = y;
    pt.z   = z;
    pt.rad = r;
    pending_points.push_back(pt);
    points_queued++;
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_plane(int a, int b, int c, int d);
    return {a[COEF_W-1:0], b[COEF_W-1:0], c[COEF_W-1:0], d[OFS_W-1:0]};
  endfunction

  task automatic write_plane(plane_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= PLANE_NEAR) plane_cfg[idx] = data;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_planes(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] l,
                             logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] t,
                             logic [CFG_DATA_W-1:0] f, logic [CFG_DATA_W-1:0] n);
    write_plane(PLANE_RIGHT, r);
    write_plane(PLANE_LEFT, l);
    write_plane(PLANE_BOTTOM, b);
    write_plane(PLANE_TOP, t);
    write_plane(PLANE_FAR, f);
    write_plane(PLANE_NEAR, n);
  endtask

  // Axis-aligned cube of half size h units; each plane faces inward.
  task automatic set_box(int h);
    int d;
    box_half = h;
    d = h * OFS_ONE;
    load_planes(pack_plane(-NORMAL_ONE, 0, 0, d), pack_plane(NORMAL_ONE, 0, 0, d),
                pack_plane(0, NORMAL_ONE, 0, d), pack_plane(0, -NORMAL_ONE, 0, d),
                pack_plane(0, 0, -NORMAL_ONE, d), pack_plane(0, 0, NORMAL_ONE, d));
  endtask

  task automatic queue_volume();
    longint h, cx, cy, cz, r, ex, ey, ez, px, py, pz;
    int     k, flip;
    h = longint'(box_half) * COORD_ONE;
    if ($urandom_range(7) == 0) begin
      push_point(OP_SPHERE, $urandom, $urandom, $urandom, RAD_W'($urandom));
      repeat (NUM_CORNERS) push_point(OP_CORNER, $urandom, $urandom, $urandom, RAD_W'($urandom));
    end else begin
      cx = rand_span(2 * h);
      cy = rand_span(2 * h);
      cz = rand_span(2 * h);
      r = ($urandom_range(9) == 0) ? 0 : longint'($urandom_range(1, 32'(h)));
      // Sphere just touching the right plane from outside: distance equals minus the radius.
      if (r != 0 && $urandom_range(7) == 0) cx = h + r;
      push_point(OP_SPHERE, 32'(cx), 32'(cy), 32'(cz), RAD_W'(r));
      ex = $urandom_range(0, 32'(h));
      ey = $urandom_range(0, 32'(h));
      ez = $urandom_range(0, 32'(h));
      flip = $urandom_range(NUM_CORNERS - 1);
      for (k = 0; k < NUM_CORNERS; k++) begin
        px = (((k ^ flip) & 1) != 0) ? cx + ex : cx - ex;
        py = (((k ^ flip) & 2) != 0) ? cy + ey : cy - ey;
        pz = (((k ^ flip) & 4) != 0) ? cz + ez : cz - ez;
        // A corner on the right plane has distance zero and is not in front of it.
        if ($urandom_range(7) == 0) px = h;
        push_point(OP_CORNER, 32'(px), 32'(py), 32'(pz), RAD_W'($urandom));
      end
    end
  endtask

  task automatic queue_noise();
    logic [RAD_W-1:0] r;
    r = ($urandom_range(3) == 0) ? '0 : RAD_W'($urandom);
    push_point(fct_op_t'($urandom_range(1)), $urandom, $urandom, $urandom, r);
  endtask

  // A sphere with too few corners, or stray corners with no sphere.
  task automatic queue_broken();
    longint h;
    int     k, n;
    h = longint'(box_half) * COORD_ONE;
    n = $urandom_range(1, NUM_CORNERS - 1);
    if ($urandom_range(1) == 0) begin
      push_point(OP_SPHERE, 32'(rand_span(2 * h)), 32'(rand_span(2 * h)), 32'(rand_span(2 * h)),
                 RAD_W'($urandom_range(0, 32'(h))));
    end
    for (k = 0; k < n; k++) begin
      push_point(OP_CORNER, 32'(rand_span(3 * h)), 32'(rand_span(3 * h)), 32'(rand_span(3 * h)),
                 RAD_W'($urandom));
    end
  endtask

  task automatic run_random(int target);
    int start, pick;
    start = points_queued;
    while (points_queued - start < target) begin
      pick = $urandom_range(99);
      if (pick < 75) queue_volume();
      else if (pick < 90) queue_noise();
      else queue_broken();
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int gap, int stall, int n);
    @(negedge clk);
    tx_gap_pct = gap;
    rx_stall_pct = stall;
    run_random(n);
    wait_drained();
  endtask

  initial begin
    longint h;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Corners with no sphere since reset use the reset planes and the reset volume state.
    @(negedge clk);
    push_point(OP_CORNER, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1);
    push_point(OP_CORNER, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0);
    repeat (NUM_CORNERS - 2) push_point(OP_CORNER, $urandom, $urandom, $urandom, '0);
    wait_drained();

    set_box(100);
    write_plane(PLANE_SPARE_A, {$urandom, $urandom});
    write_plane(PLANE_SPARE_B, '1);
    h = longint'(box_half) * COORD_ONE;
    @(negedge clk);
    push_point(OP_SPHERE, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1);
    push_point(OP_CORNER, '0, '0, '0, '0);
    push_point(OP_CORNER, 32'(h), '0, '0, '0);
    push_point(OP_CORNER, 32'(-h), 32'(h), '0, '0);
    // A new sphere in the middle of a box restarts the volume; this one is unset.
    push_point(OP_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0);
    push_point(OP_CORNER, '0, '0, '0, '1);
    push_point(OP_CORNER, 32'(h), 32'(h), 32'(h), '0);
    push_point(OP_CORNER, 32'(-h), 32'(-h), 32'(-h), '0);
    push_point(OP_CORNER, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    push_point(OP_CORNER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    push_point(OP_CORNER, 32'(h), '0, '0, '0);
    push_point(OP_CORNER, '0, 32'(-h), '0, '0);
    push_point(OP_CORNER, '0, '0, 32'(h), '0);
    wait_drained();

    set_box($urandom_range(1, 8000));
    run_phase(0, 0, 170);

    set_box($urandom_range(1, 50));
    run_phase(45, 0, 170);

    load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    write_plane(PLANE_SPARE_B, {$urandom, $urandom});
    run_phase(0, 45, 150);

    load_planes(pack_plane(COEF_MAX, COEF_MIN, COEF_MAX, OFS_MAX),
                pack_plane(COEF_MIN, COEF_MAX, COEF_MIN, OFS_MIN),
                '0, '1,
                pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, OFS_MAX),
                pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, OFS_MIN));
    run_phase(38, 38, 150);

    // The receiver holds off long enough for the core to fill and stall its input.
    set_box($urandom_range(1, 8000));
    @(negedge clk);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    rx_hold_token++;
    run_random(80);
    wait_drained();

    // The sender pauses with items still queued until every result is back.
    set_box(8000);
    @(negedge clk);
    tx_gap_pct = 38;
    rx_stall_pct = 38;
    run_random(150);
    while (pending_points.size() > 60) @(negedge clk);
    tx_paused = 1'b1;
    while (in_valid || expected_verdicts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    tx_paused = 1'b0;
    wait_drained();

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/fct_pkg.sv
design/fct_front.sv
design/fct_queue.sv
design/fct_back.sv
design/frustum_cull_test_core.sv
test/tb_top.sv
